/* rtl/timed_event_sorted_insert_queue_assert.svh */
// Assertion macros for the sorted event queue.
`ifndef TIMED_EVENT_SORTED_INSERT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_SORTED_INSERT_QUEUE_ASSERT_SVH
`ifndef SYNTH
`define TSIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TSIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSIQ_ASSERT_NOW(lbl, ante, cons, msg)
`define TSIQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/tsiq_pkg.sv */
`timescale 1ns / 1ps

package tsiq_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [7:0]  STATUS_SYS = 8'hF0;
  localparam logic [3:0]  CHAN_MASK  = 4'hF;
  localparam logic [15:0] CAP_RESET  = 16'd1024;

  localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
  localparam logic [3:0] CMD_POLY       = 4'hA;
  localparam logic [3:0] CMD_CTRL       = 4'hB;
  localparam logic [3:0] CMD_PROG       = 4'hC;
  localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
  localparam logic [3:0] CMD_BEND       = 4'hE;

  localparam logic [2:0] RANK_CTRL = 3'd0;
  localparam logic [2:0] RANK_NONE = 3'd7;

  typedef struct packed {
    logic [31:0] ev_time;
    logic [31:0] ev_tag;
    logic [1:0]  len;
    logic [23:0] data;
  } entry_t;

  typedef struct packed {
    logic   vld;
    logic   shift;
    entry_t ent;
  } tok_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  insert_position;
    logic [6:0]  entry_count;
    logic [15:0] used_bytes;
    logic        read_valid;
    entry_t      rd;
  } res_t;

  function automatic logic [2:0] cmd_rank(input logic [7:0] st);
    logic [2:0] r;
    case (st[7:4])
      CMD_CTRL:       r = 3'd0;
      CMD_PROG:       r = 3'd1;
      CMD_NOTE_OFF:   r = 3'd2;
      CMD_NOTE_ON:    r = 3'd3;
      CMD_POLY:       r = 3'd4;
      CMD_CHAN_PRESS: r = 3'd5;
      CMD_BEND:       r = 3'd6;
      default:        r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic logic stays_first(input logic [7:0] n, input logic [7:0] s);
    logic [2:0] rn;
    logic [2:0] rs;
    logic       r;
    rn = cmd_rank(n);
    rs = cmd_rank(s);
    if (n >= STATUS_SYS || s >= STATUS_SYS || (n[3:0] & CHAN_MASK) != (s[3:0] & CHAN_MASK)) begin
      r = 1'b1;
    end else if (rs == RANK_CTRL) begin
      r = 1'b1;
    end else if (rs == RANK_NONE || rn == RANK_NONE) begin
      r = 1'b0;
    end else begin
      r = (rn >= rs);
    end
    return r;
  endfunction

endpackage

/* rtl/tsiq_if.sv */
`timescale 1ns / 1ps

interface tsiq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] event_time;
  logic [31:0] event_tag;
  logic [1:0]  data_len;
  logic [7:0]  status_byte;
  logic [7:0]  data_byte1;
  logic [7:0]  data_byte2;
  logic [5:0]  read_index;

  modport source(output valid, opcode, event_time, event_tag, data_len, status_byte,
                 data_byte1, data_byte2, read_index, input ready);
  modport sink(input valid, opcode, event_time, event_tag, data_len, status_byte,
               data_byte1, data_byte2, read_index, output ready);
endinterface

interface tsiq_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  insert_position;
  logic [6:0]  entry_count;
  logic [15:0] used_bytes;
  logic        read_valid;
  logic [31:0] read_time;
  logic [31:0] read_tag;
  logic [1:0]  read_len;
  logic [23:0] read_bytes;

  modport source(output valid, accepted, insert_position, entry_count, used_bytes,
                 read_valid, read_time, read_tag, read_len, read_bytes, input ready);
  modport sink(input valid, accepted, insert_position, entry_count, used_bytes,
               read_valid, read_time, read_tag, read_len, read_bytes, output ready);
endinterface

interface tsiq_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] wdata;

  modport source(output valid, wdata, input ready);
  modport sink(input valid, wdata, output ready);
endinterface

/* rtl/timed_event_sorted_insert_queue.sv */
`timescale 1ns / 1ps
// Insert: S_INS until the step reaches N (entries held before it), then S_DONE.
// Read at K: S_RD to step K, S_RDL, S_DONE; clear, rejects, bad reads go to S_DONE.
// One request at a time; the insert token walks the cell chain one cell per cycle.
// A new request is taken while the previous result still waits at the output.
// Synchronous active-low reset empties the queue and sets capacity to 1024; no sweep.

`include "timed_event_sorted_insert_queue_assert.svh"

module timed_event_sorted_insert_queue #(
  parameter int MAX_ENTRIES  = 64,
  parameter int HEADER_BYTES = 12
) (
  input logic        clk,
  input logic        rst_n,
  tsiq_in_if.sink    in_ch,
  tsiq_out_if.source out_ch,
  tsiq_cfg_if.sink   cfg_ch
);

  localparam int IW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = (CW > 6) ? CW : 6;
  localparam logic [16:0] HDR = 17'(HEADER_BYTES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_RD   = 5'b00100,
    S_RDL  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r;
  logic [15:0]       cap_r;
  logic [CW-1:0]     cnt_r;
  logic [15:0]       used_r;
  logic [IW-1:0]     step_r;
  logic [IW-1:0]     tgt_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     rd_sel_r;
  tsiq_pkg::tok_t    inj_r;
  tsiq_pkg::res_t    res_r;
  tsiq_pkg::res_t    out_r;
  logic              out_vld_r;

  tsiq_pkg::tok_t    tok_bus [MAX_ENTRIES+1];
  tsiq_pkg::entry_t  rd_bus  [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] occ_vec;
  logic [MAX_ENTRIES-1:0] srch_vec;

  logic              in_acc;
  logic              clr;
  logic              any_srch;
  logic [16:0]       slot;
  logic              empty_ok;
  logic              room_ok;
  logic              ins_ok;
  logic              rd_ok;
  tsiq_pkg::entry_t  new_ent;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign clr          = in_acc && (in_ch.opcode == tsiq_pkg::OP_CLEAR);
  assign any_srch     = |srch_vec;

  always_comb begin
    slot     = (HDR + 17'(in_ch.data_len) + 17'd3) & ~17'd3;
    empty_ok = (HDR + 17'(in_ch.data_len)) < {1'b0, cap_r};
    room_ok  = ({1'b0, used_r} + slot) < {1'b0, cap_r};
    ins_ok   = (in_ch.data_len != 2'd0) && (cnt_r < CW'(MAX_ENTRIES)) &&
               ((cnt_r == '0) ? empty_ok : room_ok);
    rd_ok    = RW'(in_ch.read_index) < RW'(cnt_r);
    new_ent.ev_time     = in_ch.event_time;
    new_ent.ev_tag      = in_ch.event_tag;
    new_ent.len         = in_ch.data_len;
    new_ent.data[7:0]   = in_ch.status_byte;
    new_ent.data[15:8]  = (in_ch.data_len >= 2'd2) ? in_ch.data_byte1 : 8'd0;
    new_ent.data[23:16] = (in_ch.data_len == 2'd3) ? in_ch.data_byte2 : 8'd0;
  end

  assign tok_bus[0]           = inj_r;
  assign rd_bus[MAX_ENTRIES]  = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    tsiq_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clr     (clr),
      .tok_in  (tok_bus[i]),
      .tok_out (tok_bus[i+1]),
      .rd_en   (state_r == S_RD),
      .rd_sel  (rd_sel_r),
      .rd_in   (rd_bus[i+1]),
      .rd_out  (rd_bus[i]),
      .occ     (occ_vec[i]),
      .srch    (srch_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_r     <= tsiq_pkg::CAP_RESET;
      cnt_r     <= '0;
      used_r    <= '0;
      inj_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      inj_r.vld <= 1'b0;
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.wdata;
      end
      if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_r   <= '0;
            state_r <= S_DONE;
            step_r  <= '0;
            unique case (in_ch.opcode)
              tsiq_pkg::OP_INSERT: begin
                if (ins_ok) begin
                  inj_r.vld      <= 1'b1;
                  inj_r.shift    <= 1'b0;
                  inj_r.ent      <= new_ent;
                  tgt_r          <= IW'(cnt_r);
                  cnt_r          <= cnt_r + 1'b1;
                  used_r         <= used_r + slot[15:0];
                  res_r.accepted <= 1'b1;
                  state_r        <= S_INS;
                end
              end
              tsiq_pkg::OP_CLEAR: begin
                cnt_r          <= '0;
                used_r         <= '0;
                res_r.accepted <= 1'b1;
              end
              tsiq_pkg::OP_READ: begin
                res_r.accepted <= 1'b1;
                if (rd_ok) begin
                  rd_sel_r <= IW'(in_ch.read_index);
                  tgt_r    <= IW'(in_ch.read_index);
                  state_r  <= S_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS: begin
          step_r <= step_r + 1'b1;
          if (any_srch) begin
            pos_r <= step_r;
          end
          if (step_r == tgt_r) begin
            res_r.insert_position <= 7'(any_srch ? step_r : pos_r);
            state_r               <= S_DONE;
          end
        end
        S_RD: begin
          step_r <= step_r + 1'b1;
          if (step_r == tgt_r) begin
            state_r <= S_RDL;
          end
        end
        S_RDL: begin
          res_r.read_valid <= 1'b1;
          res_r.rd         <= rd_bus[0];
          state_r          <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_r || out_ch.ready) begin
            out_r             <= res_r;
            out_r.entry_count <= 7'(cnt_r);
            out_r.used_bytes  <= used_r;
            out_vld_r         <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.accepted        = out_r.accepted;
  assign out_ch.insert_position = out_r.insert_position;
  assign out_ch.entry_count     = out_r.entry_count;
  assign out_ch.used_bytes      = out_r.used_bytes;
  assign out_ch.read_valid      = out_r.read_valid;
  assign out_ch.read_time       = out_r.rd.ev_time;
  assign out_ch.read_tag        = out_r.rd.ev_tag;
  assign out_ch.read_len        = out_r.rd.len;
  assign out_ch.read_bytes      = out_r.rd.data;

  `TSIQ_ASSERT_NOW(a_tok_in_chain, 1'b1, !tok_bus[MAX_ENTRIES].vld, "insert ran off the chain")
  `TSIQ_ASSERT_NOW(a_one_search, 1'b1, $onehot0(srch_vec), "more than one insert searching")
  `TSIQ_ASSERT_NOW(a_occ_count, state_r == S_IDLE, $countones(occ_vec) == int'(cnt_r), "occupancy mismatch")
  `TSIQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_ENTRIES), "entry count over depth")
  `TSIQ_ASSERT_NEXT(a_out_load, state_r == S_DONE && (!out_vld_r || out_ch.ready), out_vld_r, "result not loaded")

endmodule

/* rtl/tsiq_cell.sv */
`timescale 1ns / 1ps

module tsiq_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  tsiq_pkg::tok_t    tok_in,
  output tsiq_pkg::tok_t    tok_out,
  input  logic              rd_en,
  input  logic [IW-1:0]     rd_sel,
  input  tsiq_pkg::entry_t  rd_in,
  output tsiq_pkg::entry_t  rd_out,
  output logic              occ,
  output logic              srch
);

  tsiq_pkg::entry_t ent_r;
  tsiq_pkg::entry_t rd_r;
  tsiq_pkg::tok_t   tok_r;
  tsiq_pkg::tok_t   tok_nxt;
  logic             occ_r;
  logic             pred;
  logic             take;

  always_comb begin
    pred = (ent_r.ev_time > tok_in.ent.ev_time) ||
           ((ent_r.ev_time == tok_in.ent.ev_time) &&
            !tsiq_pkg::stays_first(tok_in.ent.data[7:0], ent_r.data[7:0]));
    take = tok_in.vld && (!occ_r || tok_in.shift || pred);
    tok_nxt = '0;
    if (tok_in.vld && occ_r) begin
      if (!tok_in.shift && !pred) begin
        tok_nxt = tok_in;
      end else begin
        tok_nxt.vld   = 1'b1;
        tok_nxt.shift = 1'b1;
        tok_nxt.ent   = ent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (clr) begin
        occ_r <= 1'b0;
      end else if (take) begin
        occ_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r <= tok_in.ent;
    end
    if (rd_en) begin
      rd_r <= (rd_sel == IW'(IDX)) ? ent_r : rd_in;
    end
  end

  assign tok_out = tok_r;
  assign rd_out  = rd_r;
  assign occ     = occ_r;
  assign srch    = tok_in.vld && !tok_in.shift;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;
  localparam int HDR = 12;
  localparam int LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] event_time;
    logic [31:0] event_tag;
    logic [1:0]  data_len;
    logic [7:0]  status_byte;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [5:0]  read_index;
  } request_t;

  class sorted_queue_checker;
    logic [31:0] ev_times[DEPTH];
    logic [31:0] ev_tags[DEPTH];
    logic [1:0]  ev_lens[DEPTH];
    logic [23:0] ev_data[DEPTH];
    int          held = 0;
    int          bytes_used = 0;
    logic [15:0] capacity = tsiq_pkg::CAP_RESET;
    tsiq_pkg::res_t pending[$];
    int          failures = 0;
    int          stored_n = 0;
    int          refused_n = 0;
    int          reads_hit = 0;

    function logic [2:0] rank_of(logic [7:0] st);
      case (st[7:4])
        tsiq_pkg::CMD_CTRL:       return 3'd0;
        tsiq_pkg::CMD_PROG:       return 3'd1;
        tsiq_pkg::CMD_NOTE_OFF:   return 3'd2;
        tsiq_pkg::CMD_NOTE_ON:    return 3'd3;
        tsiq_pkg::CMD_POLY:       return 3'd4;
        tsiq_pkg::CMD_CHAN_PRESS: return 3'd5;
        tsiq_pkg::CMD_BEND:       return 3'd6;
        default:                  return tsiq_pkg::RANK_NONE;
      endcase
    endfunction

    function bit keeps_lead(logic [7:0] nw, logic [7:0] st);
      logic [2:0] rn;
      logic [2:0] rs;
      rn = rank_of(nw);
      rs = rank_of(st);
      if (nw >= tsiq_pkg::STATUS_SYS || st >= tsiq_pkg::STATUS_SYS ||
          nw[3:0] != st[3:0]) return 1'b1;
      if (rs == tsiq_pkg::RANK_CTRL) return 1'b1;
      if (rs == tsiq_pkg::RANK_NONE || rn == tsiq_pkg::RANK_NONE) return 1'b0;
      return rn >= rs;
    endfunction

    function void take_request(request_t r);
      tsiq_pkg::res_t e;
      int   slot;
      int   pos;
      bit   ok;
      e = '0;
      case (r.opcode)
        tsiq_pkg::OP_INSERT: begin
          slot = (HDR + int'(r.data_len) + 3) / 4 * 4;
          ok = r.data_len != 0 && held < DEPTH;
          if (ok) begin
            if (held == 0) ok = HDR + int'(r.data_len) < int'(capacity);
            else ok = bytes_used + slot < int'(capacity);
          end
          if (ok) begin
            pos = held;
            for (int i = 0; i < held; i++) begin
              if (pos == held && (ev_times[i] > r.event_time ||
                  (ev_times[i] == r.event_time &&
                   !keeps_lead(r.status_byte, ev_data[i][7:0]))))
                pos = i;
            end
            for (int i = held; i > pos; i--) begin
              ev_times[i] = ev_times[i-1];
              ev_tags[i] = ev_tags[i-1];
              ev_lens[i] = ev_lens[i-1];
              ev_data[i] = ev_data[i-1];
            end
            ev_times[pos] = r.event_time;
            ev_tags[pos] = r.event_tag;
            ev_lens[pos] = r.data_len;
            ev_data[pos] = {(r.data_len >= 2'd3) ? r.data_byte2 : 8'h00,
                            (r.data_len >= 2'd2) ? r.data_byte1 : 8'h00, r.status_byte};
            held++;
            bytes_used = (bytes_used + slot) & 16'hFFFF;
            e.accepted = 1'b1;
            e.insert_position = 7'(pos);
            stored_n++;
          end else begin
            refused_n++;
          end
        end
        tsiq_pkg::OP_CLEAR: begin
          held = 0;
          bytes_used = 0;
          e.accepted = 1'b1;
        end
        tsiq_pkg::OP_READ: begin
          e.accepted = 1'b1;
          if (int'(r.read_index) < held) begin
            e.read_valid = 1'b1;
            e.rd.ev_time = ev_times[r.read_index];
            e.rd.ev_tag = ev_tags[r.read_index];
            e.rd.len = ev_lens[r.read_index];
            e.rd.data = ev_data[r.read_index];
            reads_hit++;
          end
        end
        default: ;
      endcase
      e.entry_count = 7'(held);
      e.used_bytes = 16'(bytes_used);
      pending = {pending, e};
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(tsiq_pkg::res_t got);
      tsiq_pkg::res_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
        return;
      end
      want = pending.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("insert_position", want.insert_position, got.insert_position);
      compare("entry_count", want.entry_count, got.entry_count);
      compare("used_bytes", want.used_bytes, got.used_bytes);
      compare("read_valid", want.read_valid, got.read_valid);
      compare("read_time", want.rd.ev_time, got.rd.ev_time);
      compare("read_tag", want.rd.ev_tag, got.rd.ev_tag);
      compare("read_len", want.rd.len, got.rd.len);
      compare("read_bytes", want.rd.data, got.rd.data);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int cap_writes = 0;
  int sent_n = 0;
  sorted_queue_checker sb = new();

  tsiq_in_if  in_ch();
  tsiq_out_if out_ch();
  tsiq_cfg_if cfg_ch();

  timed_event_sorted_insert_queue uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 12);
    end
    out_ch.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    tsiq_pkg::res_t seen;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.accepted = out_ch.accepted;
      seen.insert_position = out_ch.insert_position;
      seen.entry_count = out_ch.entry_count;
      seen.used_bytes = out_ch.used_bytes;
      seen.read_valid = out_ch.read_valid;
      seen.rd.ev_time = out_ch.read_time;
      seen.rd.ev_tag = out_ch.read_tag;
      seen.rd.len = out_ch.read_len;
      seen.rd.data = out_ch.read_bytes;
      sb.check_result(seen);
    end
  end

  function automatic request_t mk_op(logic [1:0] op, logic [5:0] idx);
    request_t r;
    r = '0;
    r.opcode = op;
    r.read_index = idx;
    return r;
  endfunction

  function automatic request_t mk_insert(logic [31:0] t, logic [31:0] tag, logic [1:0] len,
                                        logic [7:0] st, logic [7:0] b1, logic [7:0] b2);
    request_t r;
    r = '0;
    r.opcode = tsiq_pkg::OP_INSERT;
    r.event_time = t;
    r.event_tag = tag;
    r.data_len = len;
    r.status_byte = st;
    r.data_byte1 = b1;
    r.data_byte2 = b2;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    logic [3:0] cmd;
    logic [3:0] chan;
    r.event_tag = $urandom;
    r.data_len = $urandom_range(1, 3);
    r.data_byte1 = $urandom_range(0, 255);
    r.data_byte2 = $urandom_range(0, 255);
    r.read_index = $urandom_range(0, 63);
    pick = $urandom_range(0, 9);
    if (pick < 5) r.event_time = $urandom_range(0, 7);
    else if (pick < 8) r.event_time = $urandom;
    else r.event_time = 32'hFFFF_FFFF - $urandom_range(0, 3);
    pick = $urandom_range(0, 19);
    cmd = $urandom_range(tsiq_pkg::CMD_NOTE_OFF, tsiq_pkg::CMD_BEND);
    chan = $urandom_range(0, 1);
    if (pick < 14) r.status_byte = {cmd, chan};
    else if (pick < 17) r.status_byte = $urandom_range(tsiq_pkg::STATUS_SYS, 255);
    else r.status_byte = $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    if (pick < 64) begin
      r.opcode = tsiq_pkg::OP_INSERT;
    end else if (pick < 86) begin
      r.opcode = tsiq_pkg::OP_READ;
      if (sb.held > 0 && $urandom_range(0, 3) != 0)
        r.read_index = $urandom_range(0, (sb.held > 63) ? 63 : sb.held);
    end else if (pick < 92) begin
      r.opcode = tsiq_pkg::OP_CLEAR;
    end else if (pick < 96) begin
      r.opcode = OP_UNUSED;
    end else begin
      r.opcode = tsiq_pkg::OP_INSERT;
      r.data_len = 2'd0;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    in_ch.valid <= 1'b1;
    in_ch.opcode <= r.opcode;
    in_ch.event_time <= r.event_time;
    in_ch.event_tag <= r.event_tag;
    in_ch.data_len <= r.data_len;
    in_ch.status_byte <= r.status_byte;
    in_ch.data_byte1 <= r.data_byte1;
    in_ch.data_byte2 <= r.data_byte2;
    in_ch.read_index <= r.read_index;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.take_request(r);
    sent_n++;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.wdata <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.capacity = v;
    cap_writes++;
  endtask

  task automatic fill_store();
    request_t r;
    send_request(mk_op(tsiq_pkg::OP_CLEAR, 6'd0));
    repeat (DEPTH + 2) begin
      r = random_request();
      r.opcode = tsiq_pkg::OP_INSERT;
      if (r.data_len == 2'd0) r.data_len = 2'd3;
      send_request(r);
    end
    send_request(mk_op(tsiq_pkg::OP_READ, 6'd63));
  endtask

  task automatic run_phase(logic [15:0] cap, int count, int idle, bit fill);
    drain();
    write_capacity(cap);
    gap_pct = idle;
    stall_pct = idle;
    if (fill) fill_store();
    repeat (count) send_request(random_request());
  endtask

  initial begin
    request_t plan[$];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= tsiq_pkg::OP_INSERT;
    in_ch.event_time <= '0;
    in_ch.event_tag <= '0;
    in_ch.data_len <= '0;
    in_ch.status_byte <= '0;
    in_ch.data_byte1 <= '0;
    in_ch.data_byte2 <= '0;
    in_ch.read_index <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd0)};
    plan = {plan, mk_op(OP_UNUSED, 6'd0)};
    plan = {plan, mk_insert(32'd100, 32'h1, 2'd0, 8'h95, 8'h3C, 8'h40)};
    plan = {plan, mk_insert(32'd100, 32'hFFFF_FFFF, 2'd3, 8'h95, 8'hFF, 8'hFF)};
    plan = {plan, mk_insert(32'd100, 32'h2, 2'd2, 8'hB5, 8'h07, 8'h00)};
    plan = {plan, mk_insert(32'd100, 32'h3, 2'd1, 8'h85, 8'h11, 8'h22)};
    plan = {plan, mk_insert(32'd100, 32'h4, 2'd3, 8'hE5, 8'h00, 8'h40)};
    plan = {plan, mk_insert(32'd100, 32'h5, 2'd3, 8'h96, 8'h3C, 8'h7F)};
    plan = {plan, mk_insert(32'd100, 32'h6, 2'd1, 8'hF8, 8'h00, 8'h00)};
    plan = {plan, mk_insert(32'd100, 32'h7, 2'd2, 8'h45, 8'h12, 8'h00)};
    plan = {plan, mk_insert(32'd100, 32'h8, 2'd2, 8'hC5, 8'h05, 8'h00)};
    plan = {plan, mk_insert(32'd100, 32'h9, 2'd2, 8'hD5, 8'h33, 8'h00)};
    plan = {plan, mk_insert(32'd100, 32'hA, 2'd3, 8'hA5, 8'h3C, 8'h10)};
    plan = {plan, mk_insert(32'd100, 32'hB, 2'd3, 8'h95, 8'h00, 8'h00)};
    plan = {plan, mk_insert(32'd0, 32'h0, 2'd1, 8'h00, 8'hFF, 8'hFF)};
    plan = {plan, mk_insert(32'hFFFF_FFFF, 32'hC, 2'd3, 8'hFF, 8'hFF, 8'hFF)};
    plan = {plan, mk_insert(32'd50, 32'hD, 2'd2, 8'hD5, 8'h7F, 8'h00)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd0)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd1)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd5)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd14)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd63)};
    plan = {plan, mk_op(tsiq_pkg::OP_CLEAR, 6'd0)};
    plan = {plan, mk_op(tsiq_pkg::OP_READ, 6'd0)};
    foreach (plan[i]) send_request(plan[i]);

    run_phase(16'd0, 25, 15, 1'b0);
    run_phase(16'd13, 20, 4, 1'b0);
    run_phase(16'd14, 30, 15, 1'b0);
    run_phase(16'd33, 40, 4, 1'b0);
    run_phase(16'hFFFF, 40, 15, 1'b1);
    run_phase(16'd200, 70, 4, 1'b0);
    run_phase(16'($urandom_range(34, 1023)), 70, 15, 1'b0);
    run_phase(16'd1024, 110, 0, 1'b0);

    drain();
    repeat (80) @(posedge clk);
    $display("Sent %0d requests over %0d capacity settings: %0d events stored, %0d refused,",
             sent_n, cap_writes, sb.stored_n, sb.refused_n);
    $display("%0d reads of stored entries; tie ordering, full store and limits exercised.",
             sb.reads_hit);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
